// ===== design/dsse_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsse_pkg
// Types, constants and the segment table shared by the four-digit decimal
// seven-segment encoder.
// ----------------------------------------------------------------------------
package dsse_pkg;

	localparam int NumW   = 16;
	localparam int SegW   = 7;
	localparam int PosW   = 2;
	localparam int DigitW = 4;
	localparam int Digits = 4;

	// Reciprocal multipliers and shifts for exact truncating division
	// of any 16-bit value.
	localparam int Q1W = 13;	// number / 10   <= 6553
	localparam int Q2W = 10;	// number / 100  <= 655
	localparam int Q3W = 7;		// number / 1000 <= 65

	localparam logic [15:0] RecipTen      = 16'd52429;	// ceil(2^19 / 10)
	localparam int          ShiftTen      = 19;
	localparam logic [16:0] RecipHundred  = 17'd83887;	// ceil(2^23 / 100)
	localparam int          ShiftHundred  = 23;
	localparam logic [16:0] RecipThousand = 17'd67109;	// ceil(2^26 / 1000)
	localparam int          ShiftThousand = 26;
	localparam logic [7:0]  RecipTenSmall = 8'd205;		// ceil(2^11 / 10)
	localparam int          ShiftTenSmall = 11;

	localparam logic [SegW-1:0] SegBlank = 7'h00;
	localparam logic [PosW-1:0] LastBeat = 2'd3;
	localparam logic [PosW-1:0] PosLeft  = 2'd0;

	typedef logic [NumW-1:0]   num_t;
	typedef logic [SegW-1:0]   seg_t;
	typedef logic [PosW-1:0]   pos_t;
	typedef logic [DigitW-1:0] digit_t;

	typedef struct packed {
		num_t           number;
		logic           zero_fill;
		logic [Q1W-1:0] q1;
		logic [Q2W-1:0] q2;
		logic [Q3W-1:0] q3;
	} dsse_quot_t;

	// Patterns indexed by position: segs[0] is leftmost, segs[3] rightmost.
	typedef seg_t [Digits-1:0] dsse_segs_t;

	function automatic seg_t seg_of(input digit_t digit);
		seg_t seg;
		unique case (digit)
			4'd0:    seg = 7'h3F;
			4'd1:    seg = 7'h06;
			4'd2:    seg = 7'h5B;
			4'd3:    seg = 7'h4F;
			4'd4:    seg = 7'h66;
			4'd5:    seg = 7'h6D;
			4'd6:    seg = 7'h7D;
			4'd7:    seg = 7'h07;
			4'd8:    seg = 7'h7F;
			4'd9:    seg = 7'h6F;
			default: seg = SegBlank;
		endcase
		return seg;
	endfunction

endpackage

// ===== design/dsse_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsse_in_if
// Input channel: one number to display and its zero-fill flag per item.
// ----------------------------------------------------------------------------
interface dsse_in_if;
	logic           valid;
	logic           ready;
	dsse_pkg::num_t number;
	logic           zero_fill;

	modport source (output valid, output number, output zero_fill, input ready);
	modport sink   (input valid, input number, input zero_fill, output ready);
endinterface

// ===== design/dsse_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsse_out_if
// Output channel: one digit write (position, pattern, last flag) per item.
// ----------------------------------------------------------------------------
interface dsse_out_if;
	logic           valid;
	logic           ready;
	dsse_pkg::pos_t position;
	dsse_pkg::seg_t segments;
	logic           last;

	modport source (output valid, output position, output segments, output last,
		input ready);
	modport sink   (input valid, input position, input segments, input last,
		output ready);
endinterface

// ===== design/dsse_divide.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsse_divide
// Input register and quotient stage: number / 10, / 100 and / 1000 by
// reciprocal multiplication, registered.
// ----------------------------------------------------------------------------
module dsse_divide (
	input  logic                 clk,
	input  logic                 arst_n,
	dsse_in_if.sink              din,
	output logic                 quot_valid,
	input  logic                 quot_ready,
	output dsse_pkg::dsse_quot_t quot
);
	import dsse_pkg::*;

	logic       valid_s1;
	logic       ready_s1;
	num_t       number_s1;
	logic       fill_s1;
	logic       valid_s2;
	logic       ready_s2;
	dsse_quot_t quot_s2;

	logic [31:0] prod_ten;
	logic [32:0] prod_hundred;
	logic [32:0] prod_thousand;

	assign ready_s2 = !valid_s2 || quot_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign din.ready = ready_s1;

	assign prod_ten      = 32'(number_s1) * 32'(RecipTen);
	assign prod_hundred  = 33'(number_s1) * 33'(RecipHundred);
	assign prod_thousand = 33'(number_s1) * 33'(RecipThousand);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1)
				valid_s1 <= din.valid;
			if (ready_s2)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (din.valid && ready_s1) begin
			number_s1 <= din.number;
			fill_s1   <= din.zero_fill;
		end
		if (valid_s1 && ready_s2) begin
			quot_s2.number    <= number_s1;
			quot_s2.zero_fill <= fill_s1;
			quot_s2.q1        <= prod_ten[ShiftTen+Q1W-1:ShiftTen];
			quot_s2.q2        <= prod_hundred[ShiftHundred+Q2W-1:ShiftHundred];
			quot_s2.q3        <= prod_thousand[ShiftThousand+Q3W-1:ShiftThousand];
		end
	end

	assign quot_valid = valid_s2;
	assign quot       = quot_s2;

endmodule

// ===== design/dsse_digits.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsse_digits
// Digit extraction from the quotients, segment lookup and leading-zero
// blanking.
// ----------------------------------------------------------------------------
module dsse_digits (
	input  dsse_pkg::dsse_quot_t quot,
	output dsse_pkg::dsse_segs_t segs
);
	import dsse_pkg::*;

	logic [15:0]    diff_ones;
	logic [12:0]    diff_tens;
	logic [9:0]     diff_hundreds;
	logic [14:0]    prod_small;
	logic [3:0]     q4;
	logic [6:0]     diff_thousands;
	digit_t         d_ones;
	digit_t         d_tens;
	digit_t         d_hundreds;
	digit_t         d_thousands;
	logic           blank;

	assign diff_ones      = quot.number - 16'(quot.q1) * 16'd10;
	assign diff_tens      = quot.q1 - 13'(quot.q2) * 13'd10;
	assign diff_hundreds  = quot.q2 - 10'(quot.q3) * 10'd10;
	assign prod_small     = 15'(quot.q3) * 15'(RecipTenSmall);
	assign q4             = prod_small[ShiftTenSmall+3:ShiftTenSmall];
	assign diff_thousands = quot.q3 - 7'(q4) * 7'd10;

	assign d_ones      = diff_ones[DigitW-1:0];
	assign d_tens      = diff_tens[DigitW-1:0];
	assign d_hundreds  = diff_hundreds[DigitW-1:0];
	assign d_thousands = diff_thousands[DigitW-1:0];

	assign blank = !quot.zero_fill;

	always_comb begin
		segs[3] = seg_of(d_ones);
		segs[2] = (blank && quot.q1 == '0) ? SegBlank : seg_of(d_tens);
		segs[1] = (blank && quot.q2 == '0) ? SegBlank : seg_of(d_hundreds);
		segs[0] = (blank && quot.q3 == '0) ? SegBlank : seg_of(d_thousands);
	end

endmodule

// ===== design/dsse_serializer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsse_serializer
// Result register for four patterns; sends them one item per cycle when
// ready, rightmost position first, and takes the next set on the last beat.
// ----------------------------------------------------------------------------
module dsse_serializer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 segs_valid,
	output logic                 segs_ready,
	input  dsse_pkg::dsse_segs_t segs,
	dsse_out_if.source           dout
);
	import dsse_pkg::*;

	logic       valid_q;
	pos_t       beat_q;
	dsse_segs_t segs_q;
	logic       at_last;
	logic       take;
	logic       load;

	assign at_last    = beat_q == LastBeat;
	assign take       = valid_q && dout.ready;
	assign segs_ready = !valid_q || (dout.ready && at_last);
	assign load       = segs_valid && segs_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			beat_q  <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			beat_q  <= '0;
		end else if (take) begin
			if (at_last)
				valid_q <= 1'b0;
			else
				beat_q <= beat_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			segs_q <= segs;
	end

	assign dout.valid    = valid_q;
	assign dout.position = ~beat_q;
	assign dout.segments = segs_q[~beat_q];
	assign dout.last     = at_last;

	a_load_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!valid_q || (dout.ready && dout.last)))
		else $error("new set loaded over undelivered digits");

	a_beat_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !dout.last) |=>
			(dout.valid && dout.position == $past(dout.position) - 2'd1))
		else $error("digit sequence skipped or stalled after a taken beat");

	a_drain_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(take && dout.last && !segs_valid) |=> !dout.valid)
		else $error("output still valid after final digit with nothing queued");

	a_last_is_leftmost: assert property (@(posedge clk) disable iff (!arst_n)
		(dout.valid && dout.last) |-> (dout.position == PosLeft && $past(load, 3)
			|| dout.position == PosLeft))
		else $error("last flag on a position other than leftmost");

endmodule

// ===== design/decimal_seven_segment_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_seven_segment_encoder
// Four-digit decimal seven-segment encoder with leading-zero blanking.
// ----------------------------------------------------------------------------
// Each input item is a 16-bit number and a zero-fill flag; it produces four
// output items, positions 3, 2, 1, 0 in that order, with last set on
// position 0. Values of 10000 and above show the thousands digit mod 10.
// Segment bit 0 is segment a, bit 6 segment g. The output port sets the
// rate, and the next item is accepted while the current four digits are
// still being sent. From input accept to the first digit an item passes
// the input register, the quotient register and the result register.
// ----------------------------------------------------------------------------
module decimal_seven_segment_encoder (
	input  logic        clk,
	input  logic        arst_n,
	dsse_in_if.sink     din,
	dsse_out_if.source  dout
);
	import dsse_pkg::*;

	logic       quot_valid;
	logic       quot_ready;
	dsse_quot_t quot;
	dsse_segs_t segs;

	dsse_divide u_divide (
		.clk        (clk),
		.arst_n     (arst_n),
		.din        (din),
		.quot_valid (quot_valid),
		.quot_ready (quot_ready),
		.quot       (quot)
	);

	dsse_digits u_digits (
		.quot (quot),
		.segs (segs)
	);

	dsse_serializer u_serializer (
		.clk        (clk),
		.arst_n     (arst_n),
		.segs_valid (quot_valid),
		.segs_ready (quot_ready),
		.segs       (segs),
		.dout       (dout)
	);

endmodule

// ===== sim/decimal_seven_segment_encoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_seven_segment_encoder_tb
// Self-checking bench for the four-digit decimal seven-segment encoder.
// ----------------------------------------------------------------------------
// Numbers go in on the input channel and four digit writes per number are
// expected back, rightmost position first, with last on the leftmost write.
// A short table covers zero, the decade edges, wrap past 9999 and both
// zero-fill settings. Random numbers follow, biased toward small values and
// decade edges, in three phases with different rates of idling on the input
// and stalling on the output. Every digit write is compared field by field
// with a queue filled from the typed table patterns or by an independent digit and blanking predictor.
// ----------------------------------------------------------------------------
module decimal_seven_segment_encoder_tb;

	import dsse_pkg::*;

	localparam int CycleLimit  = 200000;
	localparam int DrainCycles = 20;
	localparam int PhaseItems  = 130;
	localparam int Phases      = 3;

	localparam int SendIdlePct  [Phases] = '{26, 79, 0};
	localparam int RecvStallPct [Phases] = '{79, 26, 0};

	localparam seg_t DigitGlyph [10] = '{
		7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
	};

	localparam num_t DecadeEdge [5] = '{16'd9, 16'd99, 16'd999, 16'd9999, 16'd65534};

	// Index 0 is the leftmost position, as on the display.
	typedef seg_t [0:Digits-1] display_t;

	typedef struct packed {
		pos_t position;
		seg_t segments;
		logic last;
	} digit_write_t;

	typedef struct {
		num_t     number;
		logic     zero_fill;
		bit       typed;
		display_t glyphs;
	} number_row_t;

	localparam int RowCount = 23;

	number_row_t number_rows [RowCount] = '{
		'{16'd0,     1'b0, 1'b1, {SegBlank, SegBlank, SegBlank, DigitGlyph[0]}},
		'{16'd0,     1'b1, 1'b1, {DigitGlyph[0], DigitGlyph[0], DigitGlyph[0], DigitGlyph[0]}},
		'{16'd65535, 1'b0, 1'b1, {DigitGlyph[5], DigitGlyph[5], DigitGlyph[3], DigitGlyph[5]}},
		'{16'd65535, 1'b1, 1'b1, {DigitGlyph[5], DigitGlyph[5], DigitGlyph[3], DigitGlyph[5]}},
		'{16'd9999,  1'b0, 1'b1, {DigitGlyph[9], DigitGlyph[9], DigitGlyph[9], DigitGlyph[9]}},
		'{16'd10000, 1'b0, 1'b1, {DigitGlyph[0], DigitGlyph[0], DigitGlyph[0], DigitGlyph[0]}},
		'{16'd9,     1'b0, 1'b1, {SegBlank, SegBlank, SegBlank, DigitGlyph[9]}},
		'{16'd10,    1'b0, 1'b1, {SegBlank, SegBlank, DigitGlyph[1], DigitGlyph[0]}},
		'{16'd99,    1'b0, 1'b1, {SegBlank, SegBlank, DigitGlyph[9], DigitGlyph[9]}},
		'{16'd100,   1'b0, 1'b1, {SegBlank, DigitGlyph[1], DigitGlyph[0], DigitGlyph[0]}},
		'{16'd999,   1'b0, 1'b1, {SegBlank, DigitGlyph[9], DigitGlyph[9], DigitGlyph[9]}},
		'{16'd1000,  1'b0, 1'b1, {DigitGlyph[1], DigitGlyph[0], DigitGlyph[0], DigitGlyph[0]}},
		'{16'd7,     1'b1, 1'b0, '0},
		'{16'd42,    1'b0, 1'b0, '0},
		'{16'd305,   1'b1, 1'b0, '0},
		'{16'd1234,  1'b0, 1'b0, '0},
		'{16'd5678,  1'b1, 1'b0, '0},
		'{16'd20000, 1'b0, 1'b0, '0},
		'{16'd12345, 1'b0, 1'b0, '0},
		'{16'd32768, 1'b1, 1'b0, '0},
		'{16'd43690, 1'b0, 1'b0, '0},
		'{16'd21845, 1'b1, 1'b0, '0},
		'{16'd60009, 1'b0, 1'b0, '0}
	};

	logic clk;
	logic arst_n;

	int unsigned  send_idle_pct;
	int unsigned  recv_stall_pct;
	int unsigned  mismatch_count;
	int unsigned  cycle_count;
	digit_write_t pending_digits [$];
	digit_write_t oldest_digit;

	dsse_in_if  num_ch ();
	dsse_out_if digit_ch ();

	decimal_seven_segment_encoder DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (num_ch),
		.dout   (digit_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic display_t predict_digits(input num_t number, input logic zero_fill);
		display_t    glyphs;
		int unsigned rest;
		int unsigned bound;
		int unsigned digit;
		rest  = number;
		bound = 1;
		for (int k = 0; k < Digits; k++) begin
			digit = rest % 10;
			if (k > 0 && !zero_fill && number < bound && digit == 0)
				glyphs[Digits-1-k] = SegBlank;
			else
				glyphs[Digits-1-k] = DigitGlyph[digit];
			rest  = rest / 10;
			bound = bound * 10;
		end
		return glyphs;
	endfunction

	function automatic num_t pick_number();
		num_t number;
		case ($urandom_range(0, 7))
			0:       number = num_t'($urandom_range(0, 9));
			1:       number = num_t'($urandom_range(0, 99));
			2:       number = num_t'($urandom_range(0, 999));
			3:       number = num_t'($urandom_range(0, 9999));
			4:       number = DecadeEdge[$urandom_range(0, 4)] + num_t'($urandom_range(0, 1));
			default: number = num_t'($urandom_range(0, 65535));
		endcase
		return number;
	endfunction

	task automatic flag_mismatch(input string what);
		$display("[%0t] MISMATCH: %s", $realtime, what);
		mismatch_count++;
	endtask

	task automatic send_number(input num_t number, input logic zero_fill,
		input display_t glyphs);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			num_ch.valid <= 1'b0;
			@(posedge clk);
		end
		num_ch.valid     <= 1'b1;
		num_ch.number    <= number;
		num_ch.zero_fill <= zero_fill;
		do @(posedge clk); while (num_ch.ready !== 1'b1);
		for (int p = Digits - 1; p >= 0; p--)
			pending_digits.push_back('{pos_t'(p), glyphs[p], pos_t'(p) == PosLeft});
	endtask

	initial begin
		num_t number;
		logic zero_fill;
		clk              = 1'b0;
		arst_n           = 1'b0;
		num_ch.valid     = 1'b0;
		num_ch.number    = '0;
		num_ch.zero_fill = 1'b0;
		digit_ch.ready   = 1'b0;
		send_idle_pct    = 0;
		recv_stall_pct   = 0;
		mismatch_count   = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		foreach (number_rows[i]) begin
			if (number_rows[i].typed)
				send_number(number_rows[i].number, number_rows[i].zero_fill,
					number_rows[i].glyphs);
			else
				send_number(number_rows[i].number, number_rows[i].zero_fill,
					predict_digits(number_rows[i].number, number_rows[i].zero_fill));
		end

		for (int ph = 0; ph < Phases; ph++) begin
			send_idle_pct  = SendIdlePct[ph];
			recv_stall_pct = RecvStallPct[ph];
			for (int n = 0; n < PhaseItems; n++) begin
				number    = pick_number();
				zero_fill = 1'($urandom_range(0, 1));
				send_number(number, zero_fill, predict_digits(number, zero_fill));
			end
		end
		num_ch.valid <= 1'b0;

		while (pending_digits.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Check each accepted digit write, then pick the next ready.
	always @(posedge clk) begin
		if (arst_n && digit_ch.valid && digit_ch.ready) begin
			if (pending_digits.size() == 0) begin
				flag_mismatch($sformatf("unexpected write pos %0d seg %02h last %0b",
					digit_ch.position, digit_ch.segments, digit_ch.last));
			end else begin
				oldest_digit = pending_digits.pop_front();
				if (digit_ch.position !== oldest_digit.position)
					flag_mismatch($sformatf("position %0d, want %0d",
						digit_ch.position, oldest_digit.position));
				if (digit_ch.segments !== oldest_digit.segments)
					flag_mismatch($sformatf("segments %02h, want %02h at pos %0d",
						digit_ch.segments, oldest_digit.segments, oldest_digit.position));
				if (digit_ch.last !== oldest_digit.last)
					flag_mismatch($sformatf("last %0b, want %0b at pos %0d",
						digit_ch.last, oldest_digit.last, oldest_digit.position));
			end
		end
		digit_ch.ready <= arst_n && ($urandom_range(0, 99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("[%0t] TIMEOUT after %0d cycles", $realtime, cycle_count);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial cycle_count = 0;

endmodule
